FILE: src/bcb_pkg.sv
// Shared types and codes for the bandwidth calendar binner.
package bcb_pkg;

    localparam int NSUMS  = 5;
    localparam int SLOT_W = 5;
    localparam int SUM_W  = 64;
    localparam int TOT_W  = 63;
    localparam int HOUR_W = 32;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    localparam logic [1:0] TBL_SAVED = 2'd0;
    localparam logic [1:0] TBL_HOUR  = 2'd1;
    localparam logic [1:0] TBL_DAY   = 2'd2;
    localparam logic [1:0] TBL_MONTH = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE
    } t_state;

    typedef logic [NSUMS-1:0][SUM_W-1:0] t_sums;
    typedef logic [NSUMS-1:0][TOT_W-1:0] t_totals;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [HOUR_W-1:0] stats_hour_now;
        logic [4:0]        hour_of_day;
        logic [4:0]        day_of_month;
        logic [3:0]        month_index;
        logic [TOT_W-1:0]  recv_total;
        logic [TOT_W-1:0]  recv_blocked_total;
        logic [TOT_W-1:0]  sent_total;
        logic [TOT_W-1:0]  resent_total;
        logic [TOT_W-1:0]  http_total;
        logic [1:0]        read_table;
        logic [SLOT_W-1:0] read_slot;
    } t_req;

    typedef struct packed {
        logic [SUM_W-1:0]  out_recv;
        logic [SUM_W-1:0]  out_recv_blocked;
        logic [SUM_W-1:0]  out_sent;
        logic [SUM_W-1:0]  out_resent;
        logic [SUM_W-1:0]  out_http;
        logic              out_dirty;
        logic [SLOT_W-1:0] out_current_slot;
        logic [HOUR_W-1:0] out_saved_hour;
    } t_rsp;

    typedef struct packed {
        logic              rd_en;
        logic              upd_en;
        logic              sample;
        logic              flush;
        logic [SLOT_W-1:0] slot;
    } t_lane_cmd;

    typedef struct packed {
        t_sums             sums;
        logic              dirty;
        logic [SLOT_W-1:0] cur_slot;
    } t_lane_rsp;

endpackage

FILE: src/bcb_delta.sv
// Delta unit: per-total difference against the previous running totals.
module bcb_delta (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  bcb_pkg::t_totals i_totals,
    output bcb_pkg::t_sums  o_delta
);
    import bcb_pkg::*;

    t_totals r_prev;
    t_sums   r_delta;
    t_sums   n_delta;

    always_comb begin
        logic [SUM_W-1:0] diff;
        for (int k = 0; k < NSUMS; k++) begin
            diff = {1'b0, i_totals[k]} - {1'b0, r_prev[k]};
            n_delta[k] = diff[SUM_W-1] ? '0 : diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_load) begin
            r_prev <= i_totals;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_delta <= n_delta;
        end
    end

    assign o_delta = r_delta;

endmodule

FILE: src/bcb_lane.sv
// Table lane: slot memory, dirty marks and current slot of one calendar table.
module bcb_lane #(
    parameter int SLOTS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcb_pkg::t_lane_cmd i_cmd,
    input  bcb_pkg::t_sums     i_delta,
    output bcb_pkg::t_lane_rsp o_rsp
);
    import bcb_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_sums             r_mem [SLOTS];
    t_sums             r_rd;
    logic              r_rd_ok;
    logic [SLOTS-1:0]  r_valid;
    logic [SLOTS-1:0]  r_dirty;
    logic [SLOT_W-1:0] r_cur;
    logic              r_started;

    logic              in_range;
    logic [AW-1:0]     idx;
    logic              change;
    logic              wr_en;
    logic              clr_en;
    t_sums             base;
    t_sums             n_row;

    assign in_range = {1'b0, i_cmd.slot} < (SLOT_W + 1)'(SLOTS);
    assign idx      = i_cmd.slot[AW-1:0];
    assign change   = (i_cmd.slot != r_cur) || !r_started;
    assign wr_en    = i_cmd.upd_en && i_cmd.sample;
    assign clr_en   = i_cmd.upd_en && i_cmd.flush && in_range;

    always_comb begin
        if (change && r_started) begin
            base = '0;
        end else if (r_rd_ok) begin
            base = r_rd;
        end else begin
            base = '0;
        end
        for (int k = 0; k < NSUMS; k++) begin
            n_row[k] = base[k] + i_delta[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[idx] <= n_row;
        end
        if (i_cmd.rd_en && in_range) begin
            r_rd <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_dirty   <= '0;
            r_cur     <= '0;
            r_started <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_ok <= in_range ? r_valid[idx] : 1'b0;
            end
            if (wr_en) begin
                r_valid[idx] <= 1'b1;
                r_dirty[idx] <= 1'b1;
                r_cur        <= i_cmd.slot;
                r_started    <= 1'b1;
            end
            if (clr_en) begin
                r_dirty[idx] <= 1'b0;
            end
        end
    end

    assign o_rsp.sums     = r_rd_ok ? r_rd : '0;
    assign o_rsp.dirty    = in_range ? r_dirty[idx] : 1'b0;
    assign o_rsp.cur_slot = r_cur;

endmodule

FILE: src/bcb_merge.sv
// Merge stage: select the addressed lane and register the result.
module bcb_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [1:0]                i_table,
    input  bcb_pkg::t_lane_rsp        i_hour,
    input  bcb_pkg::t_lane_rsp        i_day,
    input  bcb_pkg::t_lane_rsp        i_month,
    input  logic [bcb_pkg::HOUR_W-1:0] i_saved_hour,
    input  logic                      i_saved_dirty,
    output logic                      o_strobe,
    output bcb_pkg::t_rsp             o_rsp
);
    import bcb_pkg::*;

    t_lane_rsp sel;
    t_rsp      n_rsp;
    t_rsp      r_rsp;
    logic      r_strobe;

    always_comb begin
        case (i_table)
            TBL_HOUR:  sel = i_hour;
            TBL_DAY:   sel = i_day;
            TBL_MONTH: sel = i_month;
            default: begin
                sel       = '0;
                sel.dirty = i_saved_dirty;
            end
        endcase
        n_rsp.out_recv         = sel.sums[0];
        n_rsp.out_recv_blocked = sel.sums[1];
        n_rsp.out_sent         = sel.sums[2];
        n_rsp.out_resent       = sel.sums[3];
        n_rsp.out_http         = sel.sums[4];
        n_rsp.out_dirty        = sel.dirty;
        n_rsp.out_current_slot = sel.cur_slot;
        n_rsp.out_saved_hour   = i_saved_hour;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

FILE: src/bandwidth_calendar_bins.sv
// Top level of the bandwidth calendar binner.
//
// Usage:
//   Raise start with a request on i_req; it transfers at a clock edge where
//   start is high and busy is low. A sample request forms five byte deltas
//   and adds them into the current slot of the hour, day and month tables.
//   A read or flush-read request returns one slot on o_rsp, marked by
//   o_strobe for exactly one cycle; the receiver must take it then.
// Timing:
//   busy is high after each sample, read or flush transfer while the FSM
//   passes ST_FETCH (slot memory read), then ST_UPDATE (read-modify-write
//   in all three table lanes at once), so a new request waits until both
//   are done. A read result is registered in the merge stage out of
//   ST_UPDATE. An unknown request code keeps busy low and gives no result.
// Reset:
//   i_rst_n low clears previous totals, slot valid and dirty marks, current
//   slots and the saved hour; slots read as zero until first written.
module bandwidth_calendar_bins #(
    parameter int HOUR_SLOTS  = 24,
    parameter int DAY_SLOTS   = 31,
    parameter int MONTH_SLOTS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bcb_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output bcb_pkg::t_rsp o_rsp
);
    import bcb_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_req              r_req;
    logic [HOUR_W-1:0] r_saved_hour;
    logic              r_saved_dirty;

    logic              accept;
    logic              known;
    logic              is_sample;
    logic              rd_en;
    logic              upd_en;
    logic              rsp_load;
    t_totals           totals;
    t_sums             delta;
    logic [SLOT_W-1:0] day_m1;
    logic [SLOT_W-1:0] hour_slot;
    logic [SLOT_W-1:0] day_slot;
    logic [SLOT_W-1:0] month_slot;
    t_lane_cmd         cmd_hour;
    t_lane_cmd         cmd_day;
    t_lane_cmd         cmd_month;
    t_lane_rsp         rsp_hour;
    t_lane_rsp         rsp_day;
    t_lane_rsp         rsp_month;

    assign accept    = start && !busy;
    assign known     = (i_req.req_type == REQ_SAMPLE) || (i_req.req_type == REQ_READ)
                    || (i_req.req_type == REQ_FLUSH);
    assign is_sample = r_req.req_type == REQ_SAMPLE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (accept && known) n_state = ST_FETCH;
            ST_FETCH:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy     = 1'b1;
        rd_en    = 1'b0;
        upd_en   = 1'b0;
        rsp_load = 1'b0;
        case (r_state)
            ST_IDLE:   busy = 1'b0;
            ST_FETCH:  rd_en = 1'b1;
            ST_UPDATE: begin
                upd_en   = 1'b1;
                rsp_load = !is_sample;
            end
            default:   busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_saved_hour  <= '0;
            r_saved_dirty <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && (i_req.req_type == REQ_SAMPLE)
                    && (i_req.stats_hour_now != r_saved_hour)) begin
                r_saved_hour  <= i_req.stats_hour_now;
                r_saved_dirty <= 1'b1;
            end
            if (upd_en && (r_req.req_type == REQ_FLUSH) && (r_req.read_table == TBL_SAVED)) begin
                r_saved_dirty <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign totals[0] = i_req.recv_total;
    assign totals[1] = i_req.recv_blocked_total;
    assign totals[2] = i_req.sent_total;
    assign totals[3] = i_req.resent_total;
    assign totals[4] = i_req.http_total;

    bcb_delta u_delta (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && (i_req.req_type == REQ_SAMPLE)),
        .i_totals (totals),
        .o_delta  (delta)
    );

    assign day_m1 = (r_req.day_of_month == '0) ? '0 : r_req.day_of_month - 1'b1;

    always_comb begin
        hour_slot  = ({1'b0, r_req.hour_of_day} >= (SLOT_W + 1)'(HOUR_SLOTS))
                   ? SLOT_W'(HOUR_SLOTS - 1) : r_req.hour_of_day;
        day_slot   = ({1'b0, day_m1} >= (SLOT_W + 1)'(DAY_SLOTS))
                   ? SLOT_W'(DAY_SLOTS - 1) : day_m1;
        month_slot = ({2'b00, r_req.month_index} >= (SLOT_W + 1)'(MONTH_SLOTS))
                   ? SLOT_W'(MONTH_SLOTS - 1) : {1'b0, r_req.month_index};
    end

    always_comb begin
        cmd_hour.rd_en   = rd_en;
        cmd_hour.upd_en  = upd_en;
        cmd_hour.sample  = is_sample;
        cmd_hour.flush   = (r_req.req_type == REQ_FLUSH) && (r_req.read_table == TBL_HOUR);
        cmd_hour.slot    = is_sample ? hour_slot : r_req.read_slot;
        cmd_day.rd_en    = rd_en;
        cmd_day.upd_en   = upd_en;
        cmd_day.sample   = is_sample;
        cmd_day.flush    = (r_req.req_type == REQ_FLUSH) && (r_req.read_table == TBL_DAY);
        cmd_day.slot     = is_sample ? day_slot : r_req.read_slot;
        cmd_month.rd_en  = rd_en;
        cmd_month.upd_en = upd_en;
        cmd_month.sample = is_sample;
        cmd_month.flush  = (r_req.req_type == REQ_FLUSH) && (r_req.read_table == TBL_MONTH);
        cmd_month.slot   = is_sample ? month_slot : r_req.read_slot;
    end

    bcb_lane #(.SLOTS(HOUR_SLOTS)) u_lane_hour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_hour),
        .i_delta (delta),
        .o_rsp   (rsp_hour)
    );

    bcb_lane #(.SLOTS(DAY_SLOTS)) u_lane_day (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_day),
        .i_delta (delta),
        .o_rsp   (rsp_day)
    );

    bcb_lane #(.SLOTS(MONTH_SLOTS)) u_lane_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_month),
        .i_delta (delta),
        .o_rsp   (rsp_month)
    );

    bcb_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (rsp_load),
        .i_table       (r_req.read_table),
        .i_hour        (rsp_hour),
        .i_day         (rsp_day),
        .i_month       (rsp_month),
        .i_saved_hour  (r_saved_hour),
        .i_saved_dirty (r_saved_dirty),
        .o_strobe      (o_strobe),
        .o_rsp         (o_rsp)
    );

endmodule

FILE: verif/tb_bandwidth_calendar_bins.sv
// Testbench for the bandwidth calendar binner: random and directed requests checked per field.
module tb_bandwidth_calendar_bins;
    timeunit 1ns;
    timeprecision 1ps;

    import bcb_pkg::*;

    localparam int HOUR_SLOTS  = 24;
    localparam int DAY_SLOTS   = 31;
    localparam int MONTH_SLOTS = 12;
    localparam int TBL_SIZE [3] = '{HOUR_SLOTS, DAY_SLOTS, MONTH_SLOTS};
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RAND_ITEMS  = 400;

    typedef struct packed {
        logic drain;
        t_req req;
    } t_pend;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    t_pend pending_reqs [$];
    t_rsp  expected_slots [$];
    logic  took = 1'b0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    idle_cycles = 0;
    int    mismatch_cnt = 0;

    logic [63:0]       last_totals [NSUMS];
    logic [63:0]       bin_sums [3][32][NSUMS];
    logic              bin_dirty [3][32];
    logic [SLOT_W-1:0] bin_cursor [3];
    logic              bin_started [3];
    logic [31:0]       hour_mark;
    logic              hour_mark_dirty;

    bandwidth_calendar_bins #(
        .HOUR_SLOTS(HOUR_SLOTS),
        .DAY_SLOTS(DAY_SLOTS),
        .MONTH_SLOTS(MONTH_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_req(i_req),
        .busy(busy),
        .o_strobe(o_strobe),
        .o_rsp(o_rsp)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req rand_req();
        logic [$bits(t_req)-1:0] raw;
        for (int i = 0; i < $bits(t_req); i++) begin
            raw[i] = 1'($urandom_range(0, 1));
        end
        return t_req'(raw);
    endfunction

    function automatic t_req mk_sample(logic [31:0] sh, logic [4:0] h, logic [4:0] d,
                                       logic [3:0] m, logic [62:0] tot);
        t_req r;
        r = rand_req();
        r.req_type           = REQ_SAMPLE;
        r.stats_hour_now     = sh;
        r.hour_of_day        = h;
        r.day_of_month       = d;
        r.month_index        = m;
        r.recv_total         = tot;
        r.recv_blocked_total = tot >> 1;
        r.sent_total         = tot >> 2;
        r.resent_total       = tot >> 3;
        r.http_total         = tot >> 4;
        return r;
    endfunction

    function automatic t_req mk_read(logic [1:0] rt, logic [1:0] tbl, logic [4:0] slot);
        t_req r;
        r = rand_req();
        r.req_type   = rt;
        r.read_table = tbl;
        r.read_slot  = slot;
        return r;
    endfunction

    task automatic push_item(t_req r, logic drain);
        pending_reqs.push_back({drain, r});
    endtask

    function automatic bit bin_request(input t_req r, output t_rsp e);
        logic [62:0]       tot_in [NSUMS];
        logic [63:0]       delta [NSUMS];
        logic [63:0]       cur;
        logic [SLOT_W-1:0] slot [3];
        int                t;
        e = '0;
        if (r.req_type == REQ_SAMPLE) begin
            tot_in = '{r.recv_total, r.recv_blocked_total, r.sent_total,
                       r.resent_total, r.http_total};
            for (int k = 0; k < NSUMS; k++) begin
                cur = {1'b0, tot_in[k]};
                delta[k] = (cur > last_totals[k]) ? cur - last_totals[k] : 64'd0;
                last_totals[k] = cur;
            end
            if (r.stats_hour_now != hour_mark) begin
                hour_mark = r.stats_hour_now;
                hour_mark_dirty = 1'b1;
            end
            slot[0] = (r.hour_of_day >= HOUR_SLOTS) ? SLOT_W'(HOUR_SLOTS - 1) : r.hour_of_day;
            slot[1] = (r.day_of_month == 0) ? 5'd0 : r.day_of_month - 5'd1;
            if (slot[1] >= DAY_SLOTS) slot[1] = SLOT_W'(DAY_SLOTS - 1);
            slot[2] = (r.month_index >= MONTH_SLOTS) ? SLOT_W'(MONTH_SLOTS - 1)
                                                     : SLOT_W'(r.month_index);
            for (t = 0; t < 3; t++) begin
                if (slot[t] != bin_cursor[t] || !bin_started[t]) begin
                    if (bin_started[t]) begin
                        for (int k = 0; k < NSUMS; k++) bin_sums[t][slot[t]][k] = '0;
                    end
                    bin_cursor[t] = slot[t];
                    bin_started[t] = 1'b1;
                end
                bin_dirty[t][slot[t]] = 1'b1;
                for (int k = 0; k < NSUMS; k++) begin
                    bin_sums[t][slot[t]][k] = bin_sums[t][slot[t]][k] + delta[k];
                end
            end
            return 1'b0;
        end
        if (r.req_type == REQ_READ || r.req_type == REQ_FLUSH) begin
            e.out_saved_hour = hour_mark;
            if (r.read_table == TBL_SAVED) begin
                e.out_dirty = hour_mark_dirty;
                if (r.req_type == REQ_FLUSH) hour_mark_dirty = 1'b0;
            end else begin
                t = int'(r.read_table) - 1;
                e.out_current_slot = bin_cursor[t];
                if (r.read_slot < TBL_SIZE[t]) begin
                    e.out_recv         = bin_sums[t][r.read_slot][0];
                    e.out_recv_blocked = bin_sums[t][r.read_slot][1];
                    e.out_sent         = bin_sums[t][r.read_slot][2];
                    e.out_resent       = bin_sums[t][r.read_slot][3];
                    e.out_http         = bin_sums[t][r.read_slot][4];
                    e.out_dirty        = bin_dirty[t][r.read_slot];
                    if (r.req_type == REQ_FLUSH) bin_dirty[t][r.read_slot] = 1'b0;
                end
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(string fld, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h", fld, got, want);
        mismatch_cnt++;
    endtask

    always @(negedge i_clk) begin : drive_req
        logic  nxt_start;
        t_req  nxt_req;
        t_pend item;
        nxt_start = start;
        nxt_req   = i_req;
        if (i_rst_n) begin
            if (start && took) nxt_start = 1'b0;
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() != 0 &&
                             !(pending_reqs[0].drain && expected_slots.size() != 0)) begin
                    item = pending_reqs.pop_front();
                    nxt_req = item.req;
                    nxt_start = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
        start <= nxt_start;
        i_req <= nxt_req;
    end

    always @(posedge i_clk) begin : watch_rsp
        t_rsp want;
        t_rsp got;
        logic active;
        active = 1'b0;
        took <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_strobe) begin
                active = 1'b1;
                got = o_rsp;
                if (expected_slots.size() == 0) begin
                    report_mismatch("no result expected", got.out_recv, '0);
                end else begin
                    want = expected_slots.pop_front();
                    if (got.out_recv != want.out_recv)
                        report_mismatch("out_recv", got.out_recv, want.out_recv);
                    if (got.out_recv_blocked != want.out_recv_blocked)
                        report_mismatch("out_recv_blocked", got.out_recv_blocked,
                                        want.out_recv_blocked);
                    if (got.out_sent != want.out_sent)
                        report_mismatch("out_sent", got.out_sent, want.out_sent);
                    if (got.out_resent != want.out_resent)
                        report_mismatch("out_resent", got.out_resent, want.out_resent);
                    if (got.out_http != want.out_http)
                        report_mismatch("out_http", got.out_http, want.out_http);
                    if (got.out_dirty !== want.out_dirty)
                        report_mismatch("out_dirty", 64'(got.out_dirty), 64'(want.out_dirty));
                    if (got.out_current_slot != want.out_current_slot)
                        report_mismatch("out_current_slot", 64'(got.out_current_slot),
                                        64'(want.out_current_slot));
                    if (got.out_saved_hour != want.out_saved_hour)
                        report_mismatch("out_saved_hour", 64'(got.out_saved_hour),
                                        64'(want.out_saved_hour));
                end
            end
            if (start && !busy) begin
                active = 1'b1;
                if (bin_request(i_req, want)) expected_slots.push_back(want);
            end
            idle_cycles = active ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : run_test
        logic [62:0] tot [NSUMS];
        logic [62:0] full;
        logic [31:0] shour;
        logic [4:0]  h;
        logic [4:0]  d;
        logic [3:0]  m;
        t_req        r;
        int          p;

        for (int k = 0; k < NSUMS; k++) last_totals[k] = '0;
        for (int t = 0; t < 3; t++) begin
            bin_cursor[t] = '0;
            bin_started[t] = 1'b0;
            for (int s = 0; s < 32; s++) begin
                bin_dirty[t][s] = 1'b0;
                for (int k = 0; k < NSUMS; k++) bin_sums[t][s][k] = '0;
            end
        end
        hour_mark = '0;
        hour_mark_dirty = 1'b0;
        full = '1;

        push_item(mk_read(REQ_READ, TBL_HOUR, 5'd0), 1'b0);
        push_item(mk_read(REQ_FLUSH, TBL_SAVED, 5'd0), 1'b0);
        push_item(mk_sample(32'hFFFF_FFFF, 5'd31, 5'd0, 4'd15, full), 1'b0);
        push_item(mk_read(REQ_FLUSH, TBL_HOUR, 5'd23), 1'b0);
        push_item(mk_read(REQ_READ, TBL_DAY, 5'd0), 1'b0);
        push_item(mk_read(REQ_FLUSH, TBL_MONTH, 5'd11), 1'b0);
        push_item(mk_read(REQ_FLUSH, TBL_SAVED, 5'd31), 1'b0);
        push_item(mk_read(REQ_READ, TBL_SAVED, 5'd7), 1'b0);
        push_item(mk_sample(32'hFFFF_FFFF, 5'd23, 5'd1, 4'd11, '0), 1'b1);
        push_item(mk_sample(32'hFFFF_FFFF, 5'd23, 5'd1, 4'd11, full), 1'b0);
        push_item(mk_sample(32'h0000_0000, 5'd23, 5'd1, 4'd11, '0), 1'b0);
        push_item(mk_sample(32'h0000_0000, 5'd23, 5'd1, 4'd11, full), 1'b0);
        push_item(mk_read(REQ_READ, TBL_HOUR, 5'd23), 1'b0);
        push_item(mk_sample(32'h0000_0001, 5'd5, 5'd31, 4'd0, '0), 1'b0);
        push_item(mk_sample(32'h0000_0001, 5'd23, 5'd31, 4'd0, 63'd7), 1'b0);
        push_item(mk_read(REQ_FLUSH, TBL_HOUR, 5'd23), 1'b0);
        push_item(mk_read(REQ_FLUSH, TBL_HOUR, 5'd24), 1'b0);
        push_item(mk_read(REQ_READ, TBL_DAY, 5'd31), 1'b0);
        push_item(mk_read(REQ_FLUSH, TBL_MONTH, 5'd12), 1'b0);
        push_item(mk_read(REQ_READ, TBL_HOUR, 5'd31), 1'b0);
        push_item(mk_read(REQ_UNKNOWN, TBL_HOUR, 5'd5), 1'b0);
        push_item(mk_read(REQ_FLUSH, TBL_DAY, 5'd30), 1'b0);
        push_item(mk_read(REQ_READ, TBL_MONTH, 5'd0), 1'b0);

        for (int k = 0; k < NSUMS; k++) tot[k] = 63'(rand64() >> 20);
        shour = $urandom;
        h = 5'($urandom_range(0, 23));
        d = 5'($urandom_range(1, 31));
        m = 4'($urandom_range(0, 11));
        for (int i = 0; i < RAND_ITEMS; i++) begin
            r = rand_req();
            p = $urandom_range(0, 99);
            if (p < 50) begin
                for (int k = 0; k < NSUMS; k++) begin
                    p = $urandom_range(0, 19);
                    if (p == 0) tot[k] = 63'(rand64());
                    else if (p == 1) tot[k] = tot[k] - 63'($urandom_range(0, 5000));
                    else if (p == 2) tot[k] = tot[k] + 63'(rand64() >> $urandom_range(1, 40));
                    else tot[k] = tot[k] + 63'($urandom_range(0, 1 << 20));
                end
                p = $urandom_range(0, 9);
                if (p == 6 || p == 7) begin
                    h = (h >= 23) ? 5'd0 : h + 5'd1;
                    if (h == 0) begin
                        d = (d >= 31) ? 5'd1 : d + 5'd1;
                        if (d == 1) m = (m >= 11) ? 4'd0 : m + 4'd1;
                    end
                end else if (p >= 8) begin
                    h = 5'($urandom_range(0, 31));
                    d = 5'($urandom_range(0, 31));
                    m = 4'($urandom_range(0, 15));
                end
                p = $urandom_range(0, 19);
                if (p < 5) shour = shour + 32'd1;
                else if (p == 5) shour = $urandom;
                r.req_type           = REQ_SAMPLE;
                r.stats_hour_now     = shour;
                r.hour_of_day        = h;
                r.day_of_month       = d;
                r.month_index        = m;
                r.recv_total         = tot[0];
                r.recv_blocked_total = tot[1];
                r.sent_total         = tot[2];
                r.resent_total       = tot[3];
                r.http_total         = tot[4];
            end else if (p < 95) begin
                r.req_type = $urandom_range(0, 1) ? REQ_READ : REQ_FLUSH;
                r.read_table = 2'($urandom_range(0, 3));
                if (r.read_table != TBL_SAVED && $urandom_range(0, 4) != 0)
                    r.read_slot = 5'($urandom_range(0, TBL_SIZE[int'(r.read_table) - 1] - 1));
            end else begin
                r.req_type = REQ_UNKNOWN;
            end
            push_item(r, ($urandom_range(0, 49) == 0));
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || start || expected_slots.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
